@@ sv/humidity_temp_frame_decoder_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the humidity and temperature frame decoder
// Each macro expands to a clocked concurrent assertion, or to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define HTFD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("htfd assertion failed");
`define HTFD_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("htfd forbidden condition seen");
`else
`define HTFD_ASSERT(label, prop)
`define HTFD_NEVER(label, expr)
`endif

`endif

@@ sv/htfd_pkg.sv @@
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 step for the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htfd_pkg;

    localparam int unsigned FRAME_LEN = 6;
    localparam int unsigned POS_W     = 3;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int unsigned QDEPTH  = 4;
    localparam int unsigned QADDR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    localparam int unsigned WORD_W  = 16;
    localparam int unsigned TEMP_W  = 15;
    localparam int unsigned HUM_W   = 14;
    localparam int unsigned TPROD_W = 31;
    localparam int unsigned HPROD_W = 30;

    localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd17500;
    localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
    localparam logic [TEMP_W:0]   TEMP_OFFSET = 16'd4500;
    localparam logic [16:0]       FULL_SCALE  = 17'd65535;

    localparam logic [POS_W-1:0] POS_T_MSB = 3'd0;
    localparam logic [POS_W-1:0] POS_T_LSB = 3'd1;
    localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
    localparam logic [POS_W-1:0] POS_H_MSB = 3'd3;
    localparam logic [POS_W-1:0] POS_H_LSB = 3'd4;
    localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

    // one decoded frame, handed from the front to the back
    typedef struct packed {
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] hum_word;
        logic              ok;
    } frame_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ sv/htfd_front.sv @@
// ----------------------------------------------------------------------------
// htfd_front
// Tracks the frame position, runs the CRC-8 per word and collects the raw
// words; emits one frame record on the sixth byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_decoder_unit_assert.svh"

module htfd_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            byte_en,
    input  wire logic [7:0]      rx_byte,
    input  wire logic            frame_start,
    output logic                 push,
    output htfd_pkg::frame_t     push_frame
);
    import htfd_pkg::*;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  pos_cur;
    logic [7:0]        crc_reg, crc_next;
    logic [WORD_W-1:0] temp_word_reg, temp_word_next;
    logic [WORD_W-1:0] hum_word_reg, hum_word_next;
    logic              first_ok_reg, first_ok_next;

    always_comb
    begin
        pos_cur = pos_reg;
        if (frame_start || (pos_reg > POS_H_CRC))
            pos_cur = POS_T_MSB;

        pos_next       = pos_cur + 3'd1;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        first_ok_next  = first_ok_reg;
        push           = 1'b0;

        case (pos_cur)
            POS_T_MSB:
            begin
                crc_next       = crc8_update(CRC_INIT, rx_byte);
                temp_word_next = {rx_byte, 8'd0};
            end
            POS_T_LSB:
            begin
                crc_next       = crc8_update(crc_reg, rx_byte);
                temp_word_next = {temp_word_reg[15:8], rx_byte};
            end
            POS_T_CRC:
            begin
                first_ok_next = (crc_reg == rx_byte);
                crc_next      = CRC_INIT;
            end
            POS_H_MSB:
            begin
                crc_next      = crc8_update(CRC_INIT, rx_byte);
                hum_word_next = {rx_byte, 8'd0};
            end
            POS_H_LSB:
            begin
                crc_next      = crc8_update(crc_reg, rx_byte);
                hum_word_next = {hum_word_reg[15:8], rx_byte};
            end
            default:
            begin
                crc_next = CRC_INIT;
                pos_next = POS_T_MSB;
                push     = byte_en;
            end
        endcase

        push_frame.temp_word = temp_word_reg;
        push_frame.hum_word  = hum_word_reg;
        push_frame.ok        = first_ok_reg && (crc_reg == rx_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_T_MSB;
            crc_reg <= CRC_INIT;
        end
        else if (byte_en)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // word registers are always written before the sixth byte reads them
    always_ff @(posedge clk)
    begin
        if (byte_en)
        begin
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            first_ok_reg  <= first_ok_next;
        end
    end

    `HTFD_NEVER(a_pos_in_frame, pos_reg > POS_H_CRC)

endmodule

`default_nettype wire

@@ sv/htfd_queue.sv @@
// ----------------------------------------------------------------------------
// htfd_queue
// Short register queue of frame records between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_decoder_unit_assert.svh"

module htfd_queue
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire htfd_pkg::frame_t push_frame,
    input  wire logic             pop,
    output htfd_pkg::frame_t      head_frame,
    output logic                  empty,
    output logic                  full
);
    import htfd_pkg::*;

    frame_t             entry_reg [QDEPTH];
    logic [QADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign empty      = (count_reg == '0);
    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_frame = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_frame;
    end

    `HTFD_NEVER(a_no_overflow, push && full)
    `HTFD_NEVER(a_no_underflow, pop && empty)
    `HTFD_ASSERT(a_count_tracks_ptrs,
        (count_reg == QCNT_W'(QDEPTH)) || (QADDR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[QADDR_W-1:0]))

endmodule

`default_nettype wire

@@ sv/htfd_back.sv @@
// ----------------------------------------------------------------------------
// htfd_back
// Scales raw words to centi units: multiply, divide by 65535 with a single
// add-and-compare correction, take 4500 off temperature, register the result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "humidity_temp_frame_decoder_unit_assert.svh"

module htfd_back
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire htfd_pkg::frame_t              head_frame,
    input  wire logic                          empty,
    output logic                               pop,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [htfd_pkg::TEMP_W-1:0] temperature_centi,
    output logic [htfd_pkg::HUM_W-1:0]         humidity_centi,
    output logic                               crc_status
);
    import htfd_pkg::*;

    logic               s1_valid_reg;
    logic [TPROD_W-1:0] s1_tprod_reg, s1_tprod_next;
    logic [HPROD_W-1:0] s1_hprod_reg, s1_hprod_next;
    logic               s1_ok_reg;

    logic               out_valid_reg;
    logic [TEMP_W-1:0]  temp_reg, temp_next;
    logic [HUM_W-1:0]   hum_reg, hum_next;
    logic               status_reg;

    logic               out_en;
    logic               s1_en;

    logic [TEMP_W-1:0]  t_hi;
    logic [16:0]        t_sum;
    logic [TEMP_W-1:0]  t_quot;
    logic [TEMP_W:0]    t_shift;
    logic [HUM_W-1:0]   h_hi;
    logic [16:0]        h_sum;
    logic [HUM_W-1:0]   h_quot;

    assign out_en = !out_valid_reg || out_ready;
    assign s1_en  = !s1_valid_reg || out_en;
    assign pop    = s1_en && !empty;

    assign s1_tprod_next = TPROD_W'(head_frame.temp_word) * TPROD_W'(TEMP_SCALE);
    assign s1_hprod_next = HPROD_W'(head_frame.hum_word) * HPROD_W'(HUM_SCALE);

    // x / 65535 = hi + ((hi + lo) >= 65535) while hi + lo stays below 2 * 65535
    always_comb
    begin
        t_hi    = s1_tprod_reg[TPROD_W-1:16];
        t_sum   = 17'(t_hi) + 17'(s1_tprod_reg[15:0]);
        t_quot  = t_hi + TEMP_W'(t_sum >= FULL_SCALE);
        t_shift = (TEMP_W+1)'(t_quot) - TEMP_OFFSET;

        h_hi    = s1_hprod_reg[HPROD_W-1:16];
        h_sum   = 17'(h_hi) + 17'(s1_hprod_reg[15:0]);
        h_quot  = h_hi + HUM_W'(h_sum >= FULL_SCALE);

        temp_next = s1_ok_reg ? t_shift[TEMP_W-1:0] : '0;
        hum_next  = s1_ok_reg ? h_quot : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= !empty;
            if (out_en)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_tprod_reg <= s1_tprod_next;
            s1_hprod_reg <= s1_hprod_next;
            s1_ok_reg    <= head_frame.ok;
        end
        if (out_en && s1_valid_reg)
        begin
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            status_reg <= !s1_ok_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = hum_reg;
    assign crc_status        = status_reg;

    `HTFD_ASSERT(a_stage_moves, (s1_valid_reg && out_en) |=> out_valid_reg)

endmodule

`default_nettype wire

@@ sv/humidity_temp_frame_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_unit
// The sixth byte queues a frame record, which passes the product and output registers.
// Throughput: one byte per cycle unless the queue is full; the scaler is pipelined.
// A four-entry frame queue lets bytes keep flowing while m_tready is low, until it fills.
// Reset (rst_n, async, active low) clears position, CRC, queue and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_decoder_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tuser,   // [0] frame_start
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi
    output logic             m_tuser    // [0] crc_status
);
    import htfd_pkg::*;

    logic                      byte_en;
    logic                      push;
    frame_t                    push_frame;
    frame_t                    head_frame;
    logic                      pop;
    logic                      q_empty;
    logic                      q_full;
    logic signed [TEMP_W-1:0]  temperature_centi;
    logic [HUM_W-1:0]          humidity_centi;

    // hold input while the frame queue is full
    assign s_tready = !q_full;
    assign byte_en  = s_tvalid && s_tready;

    htfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (byte_en),
        .rx_byte     (s_tdata),
        .frame_start (s_tuser),
        .push        (push),
        .push_frame  (push_frame)
    );

    htfd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .empty      (q_empty),
        .full       (q_full)
    );

    htfd_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_frame        (head_frame),
        .empty             (q_empty),
        .pop               (pop),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .crc_status        (m_tuser)
    );

    assign m_tdata = {3'd0, humidity_centi, temperature_centi};

endmodule

`default_nettype wire

@@ dv/humidity_temp_frame_decoder_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder_unit_tb
// Feeds six-byte sensor response frames into the decoder over the input
// stream, then predicts each temperature, humidity and CRC status reading and
// compares it field by field with the output stream. A short directed part
// covers the extreme raw words, restarts within a frame, frames without a
// start flag and bad CRC bytes. A random part follows, made mostly of valid
// frames with some corrupted, cut short or noise traffic, under changing
// backpressure on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_temp_frame_decoder_unit_tb;

    import htfd_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic signed [TEMP_W-1:0] temp_centi;
        logic [HUM_W-1:0]         hum_centi;
        logic                     crc_err;
    } reading_t;

    // Tracks frame position, CRC and words; queues the readings the
    // decoder owes.
    class reading_scoreboard;
        logic [POS_W-1:0]  pos;
        logic [7:0]        crc;
        logic [WORD_W-1:0] t_word;
        logic [WORD_W-1:0] h_word;
        bit                t_ok;
        reading_t          expected_readings[$];
        int                errors;

        function new();
            pos    = POS_T_MSB;
            crc    = CRC_INIT;
            t_word = '0;
            h_word = '0;
            t_ok   = 1'b0;
            errors = 0;
        endfunction

        static function logic [7:0] crc_step(logic [7:0] c_in, logic [7:0] b);
            logic [7:0] c;
            c = c_in ^ b;
            repeat (8)
            begin
                c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
            end
            return c;
        endfunction

        static function logic [7:0] word_crc(logic [WORD_W-1:0] w);
            return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            reading_t    r;
            longint      t_scaled;
            longint      h_scaled;
            bit          h_ok;
            if (start || pos >= FRAME_LEN)
                pos = POS_T_MSB;
            case (pos)
                POS_T_MSB:
                begin
                    crc    = crc_step(CRC_INIT, b);
                    t_word = {b, 8'h00};
                end
                POS_T_LSB:
                begin
                    crc    = crc_step(crc, b);
                    t_word = {t_word[15:8], b};
                end
                POS_T_CRC:
                begin
                    t_ok = (crc == b);
                    crc  = CRC_INIT;
                end
                POS_H_MSB:
                begin
                    crc    = crc_step(CRC_INIT, b);
                    h_word = {b, 8'h00};
                end
                POS_H_LSB:
                begin
                    crc    = crc_step(crc, b);
                    h_word = {h_word[15:8], b};
                end
                default:
                begin
                    h_ok = (crc == b);
                    crc  = CRC_INIT;
                    pos  = POS_T_MSB;
                    if (t_ok && h_ok)
                    begin
                        t_scaled     = (longint'(17500) * t_word) / 65535 - 4500;
                        h_scaled     = (longint'(10000) * h_word) / 65535;
                        r.temp_centi = t_scaled[TEMP_W-1:0];
                        r.hum_centi  = h_scaled[HUM_W-1:0];
                        r.crc_err    = 1'b0;
                    end
                    else
                    begin
                        r.temp_centi = '0;
                        r.hum_centi  = '0;
                        r.crc_err    = 1'b1;
                    end
                    expected_readings.push_back(r);
                    return;
                end
            endcase
            pos = pos + 1'b1;
        endfunction

        function void check_reading(logic [31:0] data, logic user);
            reading_t e;
            logic signed [TEMP_W-1:0] got_temp;
            logic [HUM_W-1:0]         got_hum;
            got_temp = data[14:0];
            got_hum  = data[28:15];
            if (expected_readings.size() == 0)
            begin
                $error("unexpected reading: tdata=%h tuser=%b", data, user);
                errors++;
                return;
            end
            e = expected_readings.pop_front();
            if (got_temp !== e.temp_centi)
            begin
                $error("temperature_centi: expected %0d, got %0d", e.temp_centi, got_temp);
                errors++;
            end
            if (got_hum !== e.hum_centi)
            begin
                $error("humidity_centi: expected %0d, got %0d", e.hum_centi, got_hum);
                errors++;
            end
            if (user !== e.crc_err)
            begin
                $error("crc_status: expected %0b, got %0b", e.crc_err, user);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] rx_byte
    logic        s_tuser  = 1'b0; // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // [14:0] temperature_centi, [28:15] humidity_centi
    logic        m_tuser;         // [0] crc_status

    int send_idle_pct = 33;
    int recv_idle_pct = 77;
    int bytes_sent    = 0;
    int stall_cycles  = 0;
    bit need_start    = 1'b1;

    reading_scoreboard readings = new();

    humidity_temp_frame_decoder_unit u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            readings.check_reading(m_tdata, m_tuser);
    end

    // Abort if neither side completes a transfer for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL humidity_temp_frame_decoder_unit");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= start;
        do
            @(posedge clk);
        while (!s_tready);
        readings.note_byte(b, start);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [WORD_W-1:0] tw, input logic [WORD_W-1:0] hw,
                              input logic start, input logic [7:0] t_flip,
                              input logic [7:0] h_flip);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = reading_scoreboard::word_crc(tw) ^ t_flip;
        hc = reading_scoreboard::word_crc(hw) ^ h_flip;
        send_byte(tw[15:8], start);
        send_byte(tw[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(hw[15:8], 1'b0);
        send_byte(hw[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    // Hold the input idle until every owed reading has been delivered.
    task automatic drain_readings();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (readings.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic send_random(input int target);
        int         kind;
        int         n;
        logic       start;
        logic [7:0] t_flip;
        logic [7:0] h_flip;
        while (bytes_sent < target)
        begin
            kind = $urandom_range(99);
            if (kind < 82)
            begin
                start      = need_start ? 1'b1 : 1'($urandom_range(1));
                need_start = 1'b0;
                t_flip     = '0;
                h_flip     = '0;
                if (kind >= 70)
                begin
                    n = $urandom_range(2);
                    if (n != 1)
                        t_flip = 8'($urandom_range(1, 255));
                    if (n != 0)
                        h_flip = 8'($urandom_range(1, 255));
                end
                send_frame(pick_word(), pick_word(), start, t_flip, h_flip);
            end
            else if (kind < 92)
            begin
                // cut a frame short; the next frame restarts explicitly
                n = $urandom_range(1, 5);
                send_byte(8'($urandom), 1'($urandom_range(1)));
                repeat (n - 1)
                    send_byte(8'($urandom), 1'b0);
                need_start = 1'b1;
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_byte(8'($urandom), ($urandom_range(7) == 0));
                need_start = 1'b1;
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 33;
        recv_idle_pct = 77;
        send_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h6666, 16'h8000, 1'b1, 8'h01, 8'h00);
        send_frame(16'h1234, 16'hBEEF, 1'b0, 8'h00, 8'h80);
        send_random(340);
        drain_readings();

        send_idle_pct = 77;
        recv_idle_pct = 33;
        need_start    = 1'b1;
        send_random(660);
        drain_readings();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        need_start    = 1'b1;
        send_random(980);
        drain_readings();

        repeat (8) @(posedge clk);
        if (readings.errors == 0)
            $display("PASS humidity_temp_frame_decoder_unit");
        else
            $display("FAIL humidity_temp_frame_decoder_unit");
        $finish;
    end

endmodule

`default_nettype wire
